// ===== hdl/multichannel_fir_filter_q15_assert.svh =====
// Assertion macros shared by the checker files.
// The clock is clk and the reset is rst in every scope that uses them.
`ifndef MULTICHANNEL_FIR_FILTER_Q15_ASSERT_SVH
`define MULTICHANNEL_FIR_FILTER_Q15_ASSERT_SVH

// Checked only outside reset.
`define MFIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked in every cycle, reset included.
`define MFIR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mfir_pkg.sv =====
// ----------------------------------------------------------------------------
// mfir_pkg
// Types and constants of the four-channel Q15 FIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mfir_pkg;

  localparam int CHANNELS    = 4;
  localparam int TAPS_DEFAULT = 32;
  localparam int SMP_W       = 10;
  localparam int COEF_W      = 16;
  localparam int CH_W        = 2;
  localparam int TAP_W       = 5;
  localparam int OUT_W       = 16;
  localparam int Q_SHIFT     = 15;
  // signed coefficient times zero-extended sample
  localparam int PROD_W      = COEF_W + SMP_W + 1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef logic        [SMP_W-1:0]  smp_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [OUT_W-1:0]  out_t;

  typedef smp_t  [CHANNELS-1:0] smp_vec_t;
  typedef coef_t [CHANNELS-1:0] coef_vec_t;
  typedef out_t  [CHANNELS-1:0] out_vec_t;

  typedef struct packed {
    logic            shift;
    logic            rotate;
    logic            coef_we;
    logic [CH_W-1:0] coef_ch;
  } cell_ctrl_t;

  typedef struct packed {
    logic clr;
    logic mul_en;
  } mac_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/mfir_if.sv =====
// ----------------------------------------------------------------------------
// mfir_in_if / mfir_out_if
// Valid/ready channels carrying input beats and filtered results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfir_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [mfir_pkg::SMP_W-1:0]  sample_ch0;
  logic [mfir_pkg::SMP_W-1:0]  sample_ch1;
  logic [mfir_pkg::SMP_W-1:0]  sample_ch2;
  logic [mfir_pkg::SMP_W-1:0]  sample_ch3;
  logic [mfir_pkg::CH_W-1:0]   coef_channel;
  logic [mfir_pkg::TAP_W-1:0]  coef_tap;
  logic signed [mfir_pkg::COEF_W-1:0] coef_value;

  modport source (output valid, kind, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                  coef_channel, coef_tap, coef_value, input ready);
  modport sink   (input valid, kind, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                  coef_channel, coef_tap, coef_value, output ready);
endinterface

interface mfir_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mfir_pkg::OUT_W-1:0] filtered_ch0;
  logic signed [mfir_pkg::OUT_W-1:0] filtered_ch1;
  logic signed [mfir_pkg::OUT_W-1:0] filtered_ch2;
  logic signed [mfir_pkg::OUT_W-1:0] filtered_ch3;

  modport source (output valid, filtered_ch0, filtered_ch1, filtered_ch2, filtered_ch3,
                  input ready);
  modport sink   (input valid, filtered_ch0, filtered_ch1, filtered_ch2, filtered_ch3,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/mfir_cell.sv =====
// ----------------------------------------------------------------------------
// mfir_cell
// One tap of the ring: a sample and a coefficient for each channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mfir_cell (
  input  wire                        clk,
  input  wire                        rst,
  input  mfir_pkg::cell_ctrl_t       ctrl,
  input  wire                        coef_sel,
  input  mfir_pkg::coef_t            coef_value,
  input  mfir_pkg::smp_vec_t         smp_left,
  input  mfir_pkg::smp_vec_t         smp_right,
  input  mfir_pkg::coef_vec_t        coef_right,
  output mfir_pkg::smp_vec_t         smp,
  output mfir_pkg::coef_vec_t        coef
);

  // shift: delay line moves one tap older
  // rotate: whole ring steps toward cell 0, which feeds the MAC
  always_ff @(posedge clk) begin
    if (rst) begin
      smp  <= '0;
      coef <= '0;
    end else if (ctrl.shift) begin
      smp <= smp_left;
    end else if (ctrl.rotate) begin
      smp  <= smp_right;
      coef <= coef_right;
    end else if (ctrl.coef_we && coef_sel) begin
      for (int c = 0; c < mfir_pkg::CHANNELS; c++) begin
        if (ctrl.coef_ch == mfir_pkg::CH_W'(c)) begin
          coef[c] <= coef_value;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mfir_mac.sv =====
// ----------------------------------------------------------------------------
// mfir_mac
// Per-channel multiply-accumulate lanes with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module mfir_mac #(
  parameter int TAPS = mfir_pkg::TAPS_DEFAULT
) (
  input  wire                   clk,
  input  wire                   rst,
  input  mfir_pkg::mac_ctrl_t   ctrl,
  input  mfir_pkg::smp_vec_t    smp,
  input  mfir_pkg::coef_vec_t   coef,
  output mfir_pkg::out_vec_t    result
);

  localparam int ACC_W = mfir_pkg::PROD_W + $clog2(TAPS) + 4;

  logic signed [mfir_pkg::PROD_W-1:0] prod [mfir_pkg::CHANNELS];
  logic signed [ACC_W-1:0]            acc  [mfir_pkg::CHANNELS];
  logic                               prod_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctrl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < mfir_pkg::CHANNELS; c++) begin
      if (ctrl.mul_en) begin
        prod[c] <= $signed(coef[c]) * $signed({1'b0, smp[c]});
      end
      if (ctrl.clr) begin
        acc[c] <= '0;
      end else if (prod_vld) begin
        acc[c] <= acc[c] + ACC_W'(prod[c]);
      end
    end
  end

  // floor shift by 15, low 16 bits kept
  always_comb begin
    for (int c = 0; c < mfir_pkg::CHANNELS; c++) begin
      result[c] = acc[c][mfir_pkg::Q_SHIFT +: mfir_pkg::OUT_W];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/multichannel_fir_filter_q15.sv =====
// ----------------------------------------------------------------------------
// multichannel_fir_filter_q15
// Four-channel FIR filter, 10-bit samples, Q15 coefficients, TAPS taps.
// ----------------------------------------------------------------------------
// A sample beat shifts one new sample per channel into the delay line, then
// the ring of TAPS cells rotates once past a single MAC lane per channel, one
// tap per cycle in RUN, then DRAIN and DONE finish the sum. The result becomes
// valid and the next beat can be taken in the same cycle, so a new sample
// beat is not taken until the last one is through. The result sits in an
// output register, so the block accepts again while it waits to be taken; a
// second finished result holds off the input until the first one is taken.
// A coefficient write beat leaves the block idle and gives no result; a tap index
// at or above TAPS is ignored. Delay line and coefficients clear to zero on
// reset. Output is the exact sum shifted right 15 (floor), low 16 bits,
// wrapping.
`default_nettype none

module multichannel_fir_filter_q15 #(
  parameter int TAPS = mfir_pkg::TAPS_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  mfir_in_if.sink     in_chan,
  mfir_out_if.source  out_chan
);

  localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

  mfir_pkg::state_t     state, state_next;
  logic [CNT_W-1:0]     cnt;
  logic                 in_acc, smp_beat, coef_beat, load, last;
  mfir_pkg::cell_ctrl_t cell_ctrl;
  mfir_pkg::mac_ctrl_t  mac_ctrl;
  mfir_pkg::smp_vec_t   smp_new;
  mfir_pkg::smp_vec_t   smp_q  [TAPS];
  mfir_pkg::coef_vec_t  coef_q [TAPS];
  mfir_pkg::out_vec_t   mac_result;
  mfir_pkg::out_vec_t   filtered;
  logic                 out_valid;

  assign in_chan.ready = (state == mfir_pkg::ST_IDLE);
  assign in_acc    = in_chan.valid && in_chan.ready;
  assign smp_beat  = in_acc && (in_chan.kind == mfir_pkg::KIND_SAMPLE);
  assign coef_beat = in_acc && (in_chan.kind == mfir_pkg::KIND_COEF);
  assign last      = (cnt == CNT_W'(TAPS - 1));

  assign smp_new[0] = in_chan.sample_ch0;
  assign smp_new[1] = in_chan.sample_ch1;
  assign smp_new[2] = in_chan.sample_ch2;
  assign smp_new[3] = in_chan.sample_ch3;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfir_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == mfir_pkg::ST_RUN) begin
        cnt <= last ? '0 : cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next        = state;
    load              = 1'b0;
    cell_ctrl.shift   = smp_beat;
    cell_ctrl.rotate  = 1'b0;
    cell_ctrl.coef_we = coef_beat;
    cell_ctrl.coef_ch = in_chan.coef_channel;
    mac_ctrl.clr      = smp_beat;
    mac_ctrl.mul_en   = 1'b0;
    case (state)
      mfir_pkg::ST_IDLE: begin
        if (smp_beat) begin
          state_next = mfir_pkg::ST_RUN;
        end
      end
      mfir_pkg::ST_RUN: begin
        cell_ctrl.rotate = 1'b1;
        mac_ctrl.mul_en  = 1'b1;
        if (last) begin
          state_next = mfir_pkg::ST_DRAIN;
        end
      end
      mfir_pkg::ST_DRAIN: begin
        state_next = mfir_pkg::ST_DONE;
      end
      mfir_pkg::ST_DONE: begin
        if (!out_valid || out_chan.ready) begin
          load       = 1'b1;
          state_next = mfir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mfir_pkg::ST_IDLE;
      end
    endcase
  end

  // ring of cells: shift takes from the left, rotate from the right
  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    mfir_pkg::smp_vec_t left;
    logic               sel;
    if (i == 0) begin : g_head
      assign left = smp_new;
    end else begin : g_body
      assign left = smp_q[i-1];
    end
    assign sel = (32'(in_chan.coef_tap) == i);

    mfir_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl),
      .coef_sel   (sel),
      .coef_value (in_chan.coef_value),
      .smp_left   (left),
      .smp_right  (smp_q[(i + 1) % TAPS]),
      .coef_right (coef_q[(i + 1) % TAPS]),
      .smp        (smp_q[i]),
      .coef       (coef_q[i])
    );
  end

  mfir_mac #(.TAPS(TAPS)) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .smp    (smp_q[0]),
    .coef   (coef_q[0]),
    .result (mac_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      filtered <= mac_result;
    end
  end

  assign out_chan.valid        = out_valid;
  assign out_chan.filtered_ch0 = filtered[0];
  assign out_chan.filtered_ch1 = filtered[1];
  assign out_chan.filtered_ch2 = filtered[2];
  assign out_chan.filtered_ch3 = filtered[3];

endmodule

`default_nettype wire

// ===== hdl/mfir_checker.sv =====
// ----------------------------------------------------------------------------
// mfir_checker
// Port-level checks of the FIR filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multichannel_fir_filter_q15_assert.svh"

module mfir_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  in_kind,
  input wire                  out_valid,
  input wire                  out_ready,
  input mfir_pkg::out_t       filtered_ch0,
  input mfir_pkg::out_t       filtered_ch1,
  input mfir_pkg::out_t       filtered_ch2,
  input mfir_pkg::out_t       filtered_ch3
);

  logic smp_beat, coef_beat, out_stall;

  assign smp_beat  = in_valid && in_ready && (in_kind == mfir_pkg::KIND_SAMPLE);
  assign coef_beat = in_valid && in_ready && (in_kind == mfir_pkg::KIND_COEF);
  assign out_stall = out_valid && !out_ready;

  `MFIR_ASSERT_ALWAYS(a_rst_no_result, rst |=> !out_valid, "result valid right after reset")

  `MFIR_ASSERT(a_coef_no_result, (coef_beat && !out_valid) |=> !out_valid,
               "coefficient write produced a result")

  `MFIR_ASSERT(a_busy_after_sample, smp_beat |=> !in_ready,
               "input taken while filtering")

  `MFIR_ASSERT(a_out_hold_valid, out_stall |=> out_valid, "result dropped while stalled")

  `MFIR_ASSERT(a_out_hold_data, out_stall |=> ($stable(filtered_ch0) && $stable(filtered_ch1)
               && $stable(filtered_ch2) && $stable(filtered_ch3)),
               "result changed while stalled")

endmodule

bind multichannel_fir_filter_q15 mfir_checker u_mfir_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_kind      (in_chan.kind),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .filtered_ch0 (out_chan.filtered_ch0),
  .filtered_ch1 (out_chan.filtered_ch1),
  .filtered_ch2 (out_chan.filtered_ch2),
  .filtered_ch3 (out_chan.filtered_ch3)
);

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the four-channel Q15 FIR filter. A queue of beats (sample sets
// and coefficient writes) feeds a valid/ready driver. Every accepted beat runs
// through a local model of the delay lines and coefficient table. Each result
// taken from the output channel is checked against the oldest predicted one.
// Both sides insert random gaps, and the receiver once holds off long enough
// to back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int TAPS       = mfir_pkg::TAPS_DEFAULT;
  localparam int NUM_BEATS  = 1950;
  localparam int CYCLE_CAP  = 600000;
  localparam int HOLD_AT    = 300;   // result count that triggers the long hold-off
  localparam int HOLD_LEN   = 400;

  typedef struct {
    logic                       kind;
    mfir_pkg::smp_vec_t         smp;
    logic [mfir_pkg::CH_W-1:0]  ch;
    logic [mfir_pkg::TAP_W-1:0] tap;
    mfir_pkg::coef_t            val;
    bit                         drain_first;  // wait for all results before sending
  } beat_t;

  logic clk;
  logic rst;

  mfir_in_if  in_chan ();
  mfir_out_if out_chan ();

  multichannel_fir_filter_q15 #(.TAPS(TAPS)) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // filter model state
  mfir_pkg::smp_t  fir_hist [mfir_pkg::CHANNELS][TAPS];
  mfir_pkg::coef_t fir_coef [mfir_pkg::CHANNELS][TAPS];
  int              fir_wpos;

  beat_t              beat_q[$];
  mfir_pkg::out_vec_t expected_out[$];

  int  cycle_cnt;
  int  err_cnt;
  int  beats_taken;
  int  results_seen;
  int  in_gap;
  int  out_stall;
  bit  in_taken;
  bit  out_taken;

  always #5 clk = ~clk;

  function automatic int draw_wait(bit calm);
    return calm ? 0 : int'($urandom_range(0, 9));
  endfunction

  function automatic mfir_pkg::smp_t pick_sample();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return mfir_pkg::smp_t'($urandom_range(0, 1023));
  endfunction

  // all fields random; the caller overrides what matters for the kind
  function automatic beat_t rand_beat(logic k);
    beat_t b;
    b.kind = k;
    for (int c = 0; c < mfir_pkg::CHANNELS; c++) b.smp[c] = pick_sample();
    b.ch  = mfir_pkg::CH_W'($urandom_range(0, mfir_pkg::CHANNELS - 1));
    b.tap = mfir_pkg::TAP_W'($urandom_range(0, 31));
    b.val = mfir_pkg::coef_t'($urandom_range(0, 65535));
    b.drain_first = 1'b0;
    return b;
  endfunction

  task automatic add_samples(input mfir_pkg::smp_t s0, s1, s2, s3);
    beat_t b;
    b = rand_beat(mfir_pkg::KIND_SAMPLE);
    b.smp[0] = s0;
    b.smp[1] = s1;
    b.smp[2] = s2;
    b.smp[3] = s3;
    beat_q.push_back(b);
  endtask

  task automatic add_coef(input int c, input int t, input mfir_pkg::coef_t v);
    beat_t b;
    b = rand_beat(mfir_pkg::KIND_COEF);
    b.ch  = mfir_pkg::CH_W'(c);
    b.tap = mfir_pkg::TAP_W'(t);
    b.val = v;
    beat_q.push_back(b);
  endtask

  // update model state; sample beats push the expected filter outputs
  task automatic fir_apply(input beat_t b);
    mfir_pkg::out_vec_t res;
    longint             acc;
    int                 idx;
    if (b.kind == mfir_pkg::KIND_COEF) begin
      if (int'(b.tap) < TAPS) fir_coef[b.ch][b.tap] = b.val;
    end else begin
      for (int c = 0; c < mfir_pkg::CHANNELS; c++) fir_hist[c][fir_wpos] = b.smp[c];
      fir_wpos = (fir_wpos + 1) % TAPS;
      for (int c = 0; c < mfir_pkg::CHANNELS; c++) begin
        acc = 0;
        for (int j = 0; j < TAPS; j++) begin
          idx = (fir_wpos - 1 - j + 2 * TAPS) % TAPS;
          acc += longint'(fir_coef[c][j]) * longint'({1'b0, fir_hist[c][idx]});
        end
        res[c] = mfir_pkg::out_t'(acc >>> mfir_pkg::Q_SHIFT);
      end
      expected_out.push_back(res);
    end
  endtask

  // input driver: changes on the falling edge
  always @(negedge clk) begin : drive_in
    beat_t nxt;
    if (rst) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_taken) begin
      if (in_chan.valid) in_gap = draw_wait((beats_taken / 200) % 4 == 1);
      if (in_gap > 0) begin
        in_gap--;
        in_chan.valid <= 1'b0;
      end else if (beat_q.size() > 0 &&
                   !(beat_q[0].drain_first && expected_out.size() > 0)) begin
        nxt = beat_q.pop_front();
        in_chan.kind         <= nxt.kind;
        in_chan.sample_ch0   <= nxt.smp[0];
        in_chan.sample_ch1   <= nxt.smp[1];
        in_chan.sample_ch2   <= nxt.smp[2];
        in_chan.sample_ch3   <= nxt.smp[3];
        in_chan.coef_channel <= nxt.ch;
        in_chan.coef_tap     <= nxt.tap;
        in_chan.coef_value   <= nxt.val;
        in_chan.valid        <= 1'b1;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // output ready: random stalls per result, one long hold-off
  always @(negedge clk) begin : drive_ready
    if (rst) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_taken) begin
        out_stall = draw_wait((results_seen / 150) % 4 == 2);
        if (results_seen == HOLD_AT) out_stall = HOLD_LEN;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // sample handshakes on the rising edge
  always @(posedge clk) begin : monitor
    beat_t              seen;
    mfir_pkg::out_vec_t want;
    mfir_pkg::out_vec_t got;
    cycle_cnt++;
    in_taken  <= !rst && in_chan.valid && in_chan.ready;
    out_taken <= !rst && out_chan.valid && out_chan.ready;
    if (!rst && out_chan.valid && out_chan.ready) begin
      results_seen++;
      got[0] = out_chan.filtered_ch0;
      got[1] = out_chan.filtered_ch1;
      got[2] = out_chan.filtered_ch2;
      got[3] = out_chan.filtered_ch3;
      if (expected_out.size() == 0) begin
        $error("unexpected result beat: %0d %0d %0d %0d",
               got[0], got[1], got[2], got[3]);
        err_cnt++;
      end else begin
        want = expected_out.pop_front();
        for (int c = 0; c < mfir_pkg::CHANNELS; c++) begin
          if (got[c] !== want[c]) begin
            $error("filtered_ch%0d: expected %0d, actual %0d", c, want[c], got[c]);
            err_cnt++;
          end
        end
      end
    end
    if (!rst && in_chan.valid && in_chan.ready) begin
      seen.kind   = in_chan.kind;
      seen.smp[0] = in_chan.sample_ch0;
      seen.smp[1] = in_chan.sample_ch1;
      seen.smp[2] = in_chan.sample_ch2;
      seen.smp[3] = in_chan.sample_ch3;
      seen.ch     = in_chan.coef_channel;
      seen.tap    = in_chan.coef_tap;
      seen.val    = in_chan.coef_value;
      fir_apply(seen);
      beats_taken++;
    end
  end

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_CAP);
    $display("[multichannel_fir_filter_q15] ERROR");
    $finish;
  end

  initial begin : stimulus
    int              total;
    int              n_directed;
    int              kind_sel;
    int              run_len;
    int              tgt;
    mfir_pkg::coef_t fill;
    beat_t           b;

    clk = 1'b0;
    rst = 1'b1;
    in_chan.valid        = 1'b0;
    in_chan.kind         = mfir_pkg::KIND_SAMPLE;
    in_chan.sample_ch0   = '0;
    in_chan.sample_ch1   = '0;
    in_chan.sample_ch2   = '0;
    in_chan.sample_ch3   = '0;
    in_chan.coef_channel = '0;
    in_chan.coef_tap     = '0;
    in_chan.coef_value   = '0;
    out_chan.ready       = 1'b0;
    cycle_cnt = 0;
    err_cnt = 0;
    beats_taken = 0;
    results_seen = 0;
    in_gap = 0;
    out_stall = 0;
    in_taken = 1'b0;
    out_taken = 1'b0;
    fir_wpos = 0;
    for (int c = 0; c < mfir_pkg::CHANNELS; c++) begin
      for (int t = 0; t < TAPS; t++) begin
        fir_hist[c][t] = '0;
        fir_coef[c][t] = '0;
      end
    end

    // directed: zero table, extreme coefficients at both ends of the line
    add_samples(10'd1023, 10'd1023, 10'd1023, 10'd1023);
    add_coef(0, 0, 16'sh7fff);
    add_coef(1, 0, 16'sh8000);
    add_coef(2, 31, 16'sh7fff);
    add_coef(3, 31, 16'sh8000);
    add_coef(0, 1, -16'sd1);
    add_coef(1, 1, 16'sd1);
    add_coef(2, 0, 16'sh4000);
    add_coef(3, 0, -16'sh4000);
    add_samples(10'd0, 10'd0, 10'd0, 10'd0);
    add_samples(10'd1023, 10'd1023, 10'd1023, 10'd1023);
    add_samples(10'd1023, 10'd0, 10'd1023, 10'd0);
    add_samples(10'h2aa, 10'h155, 10'h2aa, 10'h155);
    add_samples(10'h155, 10'h2aa, 10'h155, 10'h2aa);
    add_samples(10'd1, 10'd512, 10'd1022, 10'd511);
    add_coef(2, 0, 16'sd0);
    add_coef(0, 31, 16'sh8000);
    add_samples(10'd1023, 10'd1023, 10'd1023, 10'd1023);
    add_samples(10'd0, 10'd1023, 10'd0, 10'd1023);

    // random: runs of sample beats, whole-channel reloads, stray writes
    total = beat_q.size();
    n_directed = total;
    while (total < NUM_BEATS) begin
      kind_sel = $urandom_range(0, 99);
      if (kind_sel < 10) begin
        tgt = $urandom_range(0, mfir_pkg::CHANNELS - 1);
        case ($urandom_range(0, 2))
          0: fill = 16'sh7fff;
          1: fill = 16'sh8000;
          default: fill = '0;
        endcase
        for (int t = 0; t < TAPS; t++) begin
          if (fill == 0) add_coef(tgt, t, mfir_pkg::coef_t'($urandom_range(0, 65535)));
          else add_coef(tgt, t, fill);
        end
        total += TAPS;
      end else if (kind_sel < 16) begin
        beat_q.push_back(rand_beat(mfir_pkg::KIND_COEF));
        total++;
      end else begin
        run_len = $urandom_range(1, 40);
        for (int i = 0; i < run_len; i++) begin
          b = rand_beat(mfir_pkg::KIND_SAMPLE);
          // the first random beat and a few others wait for the pipe to empty
          if ((total == n_directed && i == 0) || (kind_sel < 20 && i == 0)) begin
            b.drain_first = 1'b1;
          end
          beat_q.push_back(b);
        end
        total += run_len;
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (beats_taken == total);
    wait (expected_out.size() == 0);
    repeat (TAPS + 8) @(posedge clk);

    if (err_cnt == 0) begin
      $display("[multichannel_fir_filter_q15] OK");
    end else begin
      $display("[multichannel_fir_filter_q15] ERROR");
    end
    $finish;
  end

endmodule
